@@ rtl/stps_pkg.sv @@
// Shared types, constants and arithmetic helpers for the sun tracker servo and power step.
// Used by stps_ctrl, stps_dp and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package stps_pkg;

	localparam int unsigned RawW   = 10;
	localparam int unsigned DutyW  = 16;
	localparam int unsigned VoltW  = 11;
	localparam int unsigned CurW   = 7;
	localparam int unsigned PwrW   = 14;
	localparam int unsigned BcdW   = 16;
	localparam int unsigned NumW   = 21;

	localparam int unsigned InTdataW  = 64;
	localparam int unsigned OutTdataW = 96;
	localparam int unsigned ApbAddrW  = 4;
	localparam int unsigned ApbDataW  = 32;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_MANUAL_MODE = 2'd0;
	localparam logic [1:0] REG_DUTY_STEP   = 2'd1;
	localparam logic [1:0] REG_DUTY_MIN    = 2'd2;
	localparam logic [1:0] REG_DUTY_MAX    = 2'd3;

	localparam logic             MODE_RESET = 1'b0;
	localparam logic [7:0]       STEP_RESET = 8'd10;
	localparam logic [DutyW-1:0] MIN_RESET  = 16'd1200;
	localparam logic [DutyW-1:0] MAX_RESET  = 16'd5000;
	localparam logic [DutyW-1:0] DUTY_RESET = 16'd3000;
	localparam logic [DutyW-1:0] DUTY_TOP   = 16'hFFFF;

	localparam logic [NumW-1:0] VOLT_FULL = 21'd1200;
	localparam logic [NumW-1:0] CUR_FULL  = 21'd100;
	localparam logic [NumW-1:0] ADC_FULL  = 21'd1023;

	typedef struct packed {
		logic             manual_mode;
		logic [7:0]       duty_step;
		logic [DutyW-1:0] duty_min;
		logic [DutyW-1:0] duty_max;
	} cfg_t;

	typedef struct packed {
		logic [RawW-1:0] light_left;
		logic [RawW-1:0] light_right;
		logic [RawW-1:0] light_up;
		logic [RawW-1:0] light_down;
		logic [RawW-1:0] panel_voltage_raw;
		logic [RawW-1:0] panel_current_raw;
		logic [3:0]      buttons;
	} sample_t;

	typedef struct packed {
		logic [DutyW-1:0] azimuth_duty;
		logic [DutyW-1:0] altitude_duty;
		logic [VoltW-1:0] voltage_scaled;
		logic [PwrW-1:0]  power_scaled;
		logic [BcdW-1:0]  voltage_bcd;
		logic [BcdW-1:0]  power_bcd;
	} result_t;

	// sequencer commands to the datapath
	typedef struct packed {
		logic       load;     // capture a sample set
		logic       move;     // one duty move, selected by step
		logic [1:0] step;
		logic       scale_v;  // voltage through the /1023 unit
		logic       scale_c;  // current through the /1023 unit
		logic       div_vt;   // voltage tenths
		logic       mul_pwr;  // power product, seed voltage digits
		logic       digit_v;  // one voltage BCD digit
		logic       div_p;    // power / 10, seed power digits
		logic       digit_p;  // one power BCD digit
		logic       emit;     // result goes to the output register
	} cmd_t;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_MOVE  = 10'b0000000010,
		ST_SCV   = 10'b0000000100,
		ST_SCC   = 10'b0000001000,
		ST_DVT   = 10'b0000010000,
		ST_MUL   = 10'b0000100000,
		ST_BCDV  = 10'b0001000000,
		ST_DVP   = 10'b0010000000,
		ST_BCDP  = 10'b0100000000,
		ST_FIN   = 10'b1000000000
	} state_t;

	// floor(v / 10) for v below 16384: reciprocal 6554 / 2^16 is exact here
	function automatic logic [10:0] div10(input logic [13:0] v);
		logic [26:0] p;
		begin
			p = {13'b0, v} * 27'd6554;
			return p[26:16];
		end
	endfunction

	// floor(x / 1023) for x below 1023 * 2048 (quotient fits 11 bits): estimate from x + x/1024, then one correction
	function automatic logic [10:0] div1023(input logic [NumW-1:0] x);
		logic [NumW-1:0] y;
		logic [NumW-1:0] prod;
		logic [NumW-1:0] r;
		logic [10:0]     q;
		begin
			y    = x + {10'b0, x[20:10]};
			q    = y[20:10];
			prod = {q, 10'b0} - {10'b0, q};
			r    = x - prod;
			if (r >= ADC_FULL) begin
				q = q + 11'd1;
			end
			return q;
		end
	endfunction

endpackage

`default_nettype wire

@@ rtl/stps_ctrl.sv @@
// Sequencer for the sun tracker step: walks duty moves, scaling and BCD digits.
// Depends on stps_pkg; drives stps_dp through stps_pkg::cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module stps_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          out_free,
	output stps_pkg::cmd_t     cmd
);

	stps_pkg::state_t state_q, state_d;
	logic [1:0]       cnt_q, cnt_d;
	logic             counting;

	assign counting = (state_q == stps_pkg::ST_MOVE) || (state_q == stps_pkg::ST_BCDV) ||
		(state_q == stps_pkg::ST_BCDP);
	assign cnt_d    = counting ? cnt_q + 2'd1 : 2'd0;
	assign in_ready = (state_q == stps_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			stps_pkg::ST_IDLE: begin
				if (in_valid) state_d = stps_pkg::ST_MOVE;
			end
			stps_pkg::ST_MOVE: begin
				if (cnt_q == 2'd3) state_d = stps_pkg::ST_SCV;
			end
			stps_pkg::ST_SCV:  state_d = stps_pkg::ST_SCC;
			stps_pkg::ST_SCC:  state_d = stps_pkg::ST_DVT;
			stps_pkg::ST_DVT:  state_d = stps_pkg::ST_MUL;
			stps_pkg::ST_MUL:  state_d = stps_pkg::ST_BCDV;
			stps_pkg::ST_BCDV: begin
				if (cnt_q == 2'd3) state_d = stps_pkg::ST_DVP;
			end
			stps_pkg::ST_DVP:  state_d = stps_pkg::ST_BCDP;
			stps_pkg::ST_BCDP: begin
				if (cnt_q == 2'd3) state_d = stps_pkg::ST_FIN;
			end
			stps_pkg::ST_FIN: begin
				if (out_free) state_d = stps_pkg::ST_IDLE;
			end
			default: state_d = stps_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stps_pkg::ST_IDLE;
			cnt_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == stps_pkg::ST_IDLE) && in_valid;
		cmd.move    = (state_q == stps_pkg::ST_MOVE);
		cmd.step    = cnt_q;
		cmd.scale_v = (state_q == stps_pkg::ST_SCV);
		cmd.scale_c = (state_q == stps_pkg::ST_SCC);
		cmd.div_vt  = (state_q == stps_pkg::ST_DVT);
		cmd.mul_pwr = (state_q == stps_pkg::ST_MUL);
		cmd.digit_v = (state_q == stps_pkg::ST_BCDV);
		cmd.div_p   = (state_q == stps_pkg::ST_DVP);
		cmd.digit_p = (state_q == stps_pkg::ST_BCDP);
		cmd.emit    = (state_q == stps_pkg::ST_FIN) && out_free;
	end

endmodule

`default_nettype wire

@@ rtl/stps_dp.sv @@
// Datapath for the sun tracker step: duty registers, /1023 and /10 units, BCD digit loop.
// Depends on stps_pkg; controlled by stps_ctrl through stps_pkg::cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module stps_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire stps_pkg::cmd_t    cmd,
	input  wire stps_pkg::cfg_t    cfg,
	input  wire stps_pkg::sample_t sample,
	output stps_pkg::result_t    result
);

	stps_pkg::sample_t smp_q;
	logic [stps_pkg::DutyW-1:0] az_q, alt_q;
	logic [stps_pkg::VoltW-1:0] volt_q;
	logic [stps_pkg::CurW-1:0]  cur_q;
	logic [stps_pkg::CurW-1:0]  vt_q;
	logic [stps_pkg::PwrW-1:0]  pwr_q;
	logic [stps_pkg::VoltW-1:0] work_q;
	logic [stps_pkg::BcdW-1:0]  vbcd_q, pbcd_q;

	// duty move
	logic                       mv_en, mv_alt, mv_up;
	logic [stps_pkg::DutyW-1:0] d_cur, d_new;
	logic [stps_pkg::DutyW:0]   d_sum;

	always_comb begin
		mv_en  = 1'b0;
		mv_alt = 1'b0;
		mv_up  = 1'b0;
		if (cfg.manual_mode) begin
			case (cmd.step)
				2'd0: begin mv_en = smp_q.buttons[3]; mv_alt = 1'b1; mv_up = 1'b1; end
				2'd1: begin mv_en = smp_q.buttons[2]; mv_alt = 1'b0; mv_up = 1'b1; end
				2'd2: begin mv_en = smp_q.buttons[1]; mv_alt = 1'b1; mv_up = 1'b0; end
				default: begin mv_en = smp_q.buttons[0]; mv_alt = 1'b0; mv_up = 1'b0; end
			endcase
		end else begin
			case (cmd.step)
				2'd0: begin
					mv_en = smp_q.light_right > smp_q.light_left; mv_alt = 1'b0; mv_up = 1'b1;
				end
				2'd1: begin
					mv_en = smp_q.light_left > smp_q.light_right; mv_alt = 1'b0; mv_up = 1'b0;
				end
				2'd2: begin
					mv_en = smp_q.light_down > smp_q.light_up; mv_alt = 1'b1; mv_up = 1'b1;
				end
				default: begin
					mv_en = smp_q.light_up > smp_q.light_down; mv_alt = 1'b1; mv_up = 1'b0;
				end
			endcase
		end
	end

	assign d_cur = mv_alt ? alt_q : az_q;
	assign d_sum = {1'b0, d_cur} + {9'b0, cfg.duty_step};

	always_comb begin
		d_new = d_cur;
		if (mv_up) begin
			if (d_cur < cfg.duty_max) begin
				d_new = d_sum[stps_pkg::DutyW] ? stps_pkg::DUTY_TOP : d_sum[stps_pkg::DutyW-1:0];
			end
		end else begin
			if (d_cur > cfg.duty_min) begin
				d_new = (d_cur >= {8'b0, cfg.duty_step}) ? d_cur - {8'b0, cfg.duty_step} : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			az_q  <= stps_pkg::DUTY_RESET;
			alt_q <= stps_pkg::DUTY_RESET;
		end else if (cmd.move && mv_en) begin
			if (mv_alt) alt_q <= d_new;
			else        az_q  <= d_new;
		end
	end

	// shared /1023 unit, voltage then current
	logic [stps_pkg::NumW-1:0] num;
	logic [10:0]               quo1023;

	assign num = cmd.scale_v ?
		{11'b0, smp_q.panel_voltage_raw} * stps_pkg::VOLT_FULL :
		{11'b0, smp_q.panel_current_raw} * stps_pkg::CUR_FULL;
	assign quo1023 = stps_pkg::div1023(num);

	// shared /10 unit for tenths, power / 10 and each digit
	logic [13:0] div_in;
	logic [10:0] quo10;
	logic [10:0] tens;
	logic [10:0] rem10;

	always_comb begin
		if (cmd.div_vt)     div_in = {3'b0, volt_q};
		else if (cmd.div_p) div_in = pwr_q;
		else                div_in = {3'b0, work_q};
	end

	assign quo10 = stps_pkg::div10(div_in);
	assign tens  = quo10 * 11'd10;
	assign rem10 = work_q - tens;

	always_ff @(posedge clk) begin
		if (cmd.load)    smp_q  <= sample;
		if (cmd.scale_v) volt_q <= quo1023;
		if (cmd.scale_c) cur_q  <= quo1023[stps_pkg::CurW-1:0];
		if (cmd.div_vt)  vt_q   <= quo10[stps_pkg::CurW-1:0];
		if (cmd.mul_pwr) begin
			pwr_q  <= {7'b0, vt_q} * {7'b0, cur_q};
			work_q <= volt_q;
		end
		if (cmd.digit_v) begin
			work_q <= quo10;
			vbcd_q <= {rem10[3:0], vbcd_q[stps_pkg::BcdW-1:4]};
		end
		if (cmd.div_p)   work_q <= quo10;
		if (cmd.digit_p) begin
			work_q <= quo10;
			pbcd_q <= {rem10[3:0], pbcd_q[stps_pkg::BcdW-1:4]};
		end
	end

	assign result.azimuth_duty   = az_q;
	assign result.altitude_duty  = alt_q;
	assign result.voltage_scaled = volt_q;
	assign result.power_scaled   = pwr_q;
	assign result.voltage_bcd    = vbcd_q;
	assign result.power_bcd      = pbcd_q;

endmodule

`default_nettype wire

@@ rtl/sun_tracker_servo_and_power_step_core.sv @@
// Top level of the sun tracker servo and power step: stream ports, APB registers, output register.
// Depends on stps_pkg, stps_ctrl and stps_dp.
//
// Use:
//  - s_axis carries one sample set per transfer: four light readings, panel voltage and
//    current readings and the manual buttons. Each transfer moves the azimuth and altitude
//    servo duty values by at most one step per move and yields one result on m_axis:
//    both duty values, scaled voltage and power, and their four-digit BCD forms.
//  - The APB port holds manual_mode, duty_step, duty_min and duty_max at byte addresses
//    0, 4, 8 and 12. pready is tied high; write only while the block is idle.
//  - A sample set is taken only in the idle state; from its transfer to the next possible one
//    it passes through the idle cycle that takes the transfer, four sequential duty moves,
//    voltage and current scaling, the voltage tenths, the power product, eight BCD digits at
//    one per cycle through a single /10 unit (four voltage digits, the power tenths step, then
//    four power digits) and the output step, where its result goes to m_axis.
//  - A finished result waits in the output register; s_axis accepts the next sample set
//    meanwhile. If m_axis stalls, the next result is held in the sequencer's last state
//    until the register frees.
//  - Reset clears the registers to their defaults, both duty values to 3000 and drops
//    any result in flight.
`timescale 1ns / 1ps
`default_nettype none

module sun_tracker_servo_and_power_step_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// light_left, light_right, light_up, light_down, panel_voltage_raw,
	// panel_current_raw (10 bits each), buttons (4 bits)
	input  wire logic [stps_pkg::InTdataW-1:0]   s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// azimuth_duty (16), altitude_duty (16), voltage_scaled (11), power_scaled (14),
	// voltage_bcd (16), power_bcd (16), zero fill (7)
	output logic [stps_pkg::OutTdataW-1:0]       m_axis_tdata,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [stps_pkg::ApbAddrW-1:0]   paddr,
	input  wire logic [stps_pkg::ApbDataW-1:0]   pwdata,
	output logic [stps_pkg::ApbDataW-1:0]        prdata,
	output logic                                 pready
);

	stps_pkg::cfg_t    cfg_q;
	stps_pkg::sample_t sample;
	stps_pkg::result_t result;
	stps_pkg::cmd_t    cmd;
	logic              out_free;
	logic              cfg_wr;

	// register file: a write lands on the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.manual_mode <= stps_pkg::MODE_RESET;
			cfg_q.duty_step   <= stps_pkg::STEP_RESET;
			cfg_q.duty_min    <= stps_pkg::MIN_RESET;
			cfg_q.duty_max    <= stps_pkg::MAX_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				stps_pkg::REG_MANUAL_MODE: cfg_q.manual_mode <= pwdata[0];
				stps_pkg::REG_DUTY_STEP:   cfg_q.duty_step   <= pwdata[7:0];
				stps_pkg::REG_DUTY_MIN:    cfg_q.duty_min    <= pwdata[15:0];
				stps_pkg::REG_DUTY_MAX:    cfg_q.duty_max    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			stps_pkg::REG_MANUAL_MODE: prdata = {31'b0, cfg_q.manual_mode};
			stps_pkg::REG_DUTY_STEP:   prdata = {24'b0, cfg_q.duty_step};
			stps_pkg::REG_DUTY_MIN:    prdata = {16'b0, cfg_q.duty_min};
			stps_pkg::REG_DUTY_MAX:    prdata = {16'b0, cfg_q.duty_max};
			default:                   prdata = '0;
		endcase
	end

	// unpack the sample set, first field lowest
	assign sample.light_left        = s_axis_tdata[9:0];
	assign sample.light_right       = s_axis_tdata[19:10];
	assign sample.light_up          = s_axis_tdata[29:20];
	assign sample.light_down        = s_axis_tdata[39:30];
	assign sample.panel_voltage_raw = s_axis_tdata[49:40];
	assign sample.panel_current_raw = s_axis_tdata[59:50];
	assign sample.buttons           = s_axis_tdata[63:60];

	// output register frees when empty or taken in this cycle
	assign out_free = !m_axis_tvalid || m_axis_tready;

	stps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_free (out_free),
		.cmd      (cmd)
	);

	stps_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.sample (sample),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (cmd.emit) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	// pack the result, first field lowest; hold while stalled
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_axis_tdata <= {7'b0, result.power_bcd, result.voltage_bcd, result.power_scaled,
				result.voltage_scaled, result.altitude_duty, result.azimuth_duty};
		end
	end

endmodule

`default_nettype wire

@@ rtl/stps_chk.sv @@
// Port-level checker for the sun tracker step core, bound onto the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module stps_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [95:0] m_axis_tdata
);

	// no result survives reset
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result valid during reset");

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// one sample set in work at a time
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a sample set is in work");

	// a new result only comes out of a sequencer pass
	a_out_from_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without a pass");

endmodule

bind sun_tracker_servo_and_power_step_core stps_chk u_stps_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
